// ----- rtl/i2ct_pkg.sv -----
// Shared types and constants for the I2C target register file.
// Holds the request and response words, command codes and statistic numbering.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package i2ct_pkg;

   // Command codes carried in the request word.
   localparam logic [3:0] CMD_ADDR_WRITE  = 4'd0;
   localparam logic [3:0] CMD_ADDR_READ   = 4'd1;
   localparam logic [3:0] CMD_RX_BYTE     = 4'd2;
   localparam logic [3:0] CMD_TX_DONE     = 4'd3;
   localparam logic [3:0] CMD_STOP        = 4'd4;
   localparam logic [3:0] CMD_BUS_ERROR   = 4'd5;
   localparam logic [3:0] CMD_LOCAL_READ  = 4'd6;
   localparam logic [3:0] CMD_LOCAL_WRITE = 4'd7;
   localparam logic [3:0] CMD_STAT_READ   = 4'd8;
   localparam logic [3:0] CMD_STAT_CLEAR  = 4'd9;

   // Bit positions inside the error flags.
   localparam int ERR_ACK_FAIL = 0;
   localparam int ERR_BUS      = 1;
   localparam int ERR_ARB_LOST = 2;
   localparam int ERR_OVERRUN  = 3;
   localparam int ERR_MISC     = 4;

   // Statistic numbering; entries below NUM_COUNTERS are event counters.
   localparam int NUM_COUNTERS = 11;
   localparam int CNT_ADDR_WRITE = 0;
   localparam int CNT_ADDR_READ  = 1;
   localparam int CNT_RX         = 2;
   localparam int CNT_TX         = 3;
   localparam int CNT_STOP       = 4;
   localparam int CNT_ACK_FAIL   = 5;
   localparam int CNT_BUS_ERR    = 6;
   localparam int CNT_ARB_LOST   = 7;
   localparam int CNT_OVERRUN    = 8;
   localparam int CNT_OTHER      = 9;
   localparam int CNT_RECOVER    = 10;
   localparam logic [3:0] STAT_LAST_ERROR = 4'd11;

   localparam logic [7:0] ZERO_BYTE = 8'h00;

   typedef struct packed {
      logic [3:0] command;
      logic [7:0] data_byte;
      logic [7:0] local_addr;
      logic [4:0] error_flags;
      logic [3:0] stat_index;
   } req_type;

   typedef struct packed {
      logic [7:0]  tx_byte;
      logic        tx_valid;
      logic [7:0]  read_data;
      logic [31:0] stat_value;
      logic        reinit_request;
   } rsp_type;

   // Update controls from the sequencer to the statistics block.
   typedef struct packed {
      logic [NUM_COUNTERS-1:0] bump;
      logic                    clear;
      logic                    err_write;
      logic [4:0]              err_flags;
   } stat_ctl_type;

endpackage

// ----- rtl/i2ct_stats.sv -----
// Event counters and last-error register of the I2C target register file.
// Depends on i2ct_pkg for the control struct and statistic numbering.
`timescale 1ns / 1ps

module i2ct_stats (
   input  logic                 clock,
   input  logic                 reset,
   input  i2ct_pkg::stat_ctl_type ctl,
   input  logic [3:0]           stat_index,
   output logic [31:0]          stat_value
);
   import i2ct_pkg::*;

   logic [31:0] counters_ff [NUM_COUNTERS];
   logic [31:0] counters_in [NUM_COUNTERS];
   logic [4:0]  last_error_ff;
   logic [4:0]  last_error_in;

   // Each counter has its own incrementer; a clear wins over any bump.
   always_comb begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
         if (ctl.clear) begin
            counters_in[i] = '0;
         end else if (ctl.bump[i]) begin
            counters_in[i] = counters_ff[i] + 32'd1;
         end else begin
            counters_in[i] = counters_ff[i];
         end
      end
      if (ctl.clear) begin
         last_error_in = '0;
      end else if (ctl.err_write) begin
         last_error_in = ctl.err_flags;
      end else begin
         last_error_in = last_error_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            counters_ff[i] <= '0;
         end
         last_error_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            counters_ff[i] <= counters_in[i];
         end
         last_error_ff <= last_error_in;
      end
   end

   always_comb begin
      if (stat_index < 4'(NUM_COUNTERS)) begin
         stat_value = counters_ff[stat_index];
      end else if (stat_index == STAT_LAST_ERROR) begin
         stat_value = {27'd0, last_error_ff};
      end else begin
         stat_value = '0;
      end
   end

`ifndef SYNTHESIS
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> (counters_ff[CNT_RECOVER] == 32'd0) && (last_error_ff == 5'd0))
      else $error("statistics not cleared");
   a_last_error: assert property (@(posedge clock) disable iff (reset)
      (ctl.err_write && !ctl.clear) |=> (last_error_ff == $past(ctl.err_flags)))
      else $error("last error not captured");
   a_bump_step: assert property (@(posedge clock) disable iff (reset)
      (ctl.bump[CNT_STOP] && !ctl.clear)
         |=> (counters_ff[CNT_STOP] == $past(counters_ff[CNT_STOP]) + 32'd1))
      else $error("stop counter did not advance by one");
`endif

endmodule

// ----- rtl/i2c_target_register_file.sv -----
// Top level of the I2C target register file: sequencer, register store memory.
// Depends on i2ct_pkg for the words and codes and on i2ct_stats for statistics.
`timescale 1ns / 1ps

//  Channel   Handshake              Payload    Direction
//  request   start high, busy low   req_word   in
//  response  rsp_strobe (1 cycle)   rsp_word   out
//
// For every word, at the accepting edge the store is read at the
// pointer (or at the local address), and in the following cycle the byte is
// used, the store and counters are written back and busy is high. The response
// is registered and shows for one cycle right after, while the next word can
// already be accepted; no new word is taken while busy is high.
// Reset is synchronous; it clears the pointer, the statistics and the valid
// bits of the store, so the store reads as zero with no clearing pass.
// The receiver cannot stall; only busy holds off the sender.

module i2c_target_register_file #(
   parameter int STORE_BYTES = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  i2ct_pkg::req_type req_word,
   output logic              rsp_strobe,
   output i2ct_pkg::rsp_type rsp_word
);
   import i2ct_pkg::*;

   localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam logic [8:0] STORE_LIMIT = 9'(STORE_BYTES);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Register store: data without reset, one valid bit per entry with reset.
   logic [7:0]             mem [STORE_BYTES];
   logic [STORE_BYTES-1:0] valid_ff;
   logic [7:0]             rd_data_ff;
   logic                   rd_valid_ff;

   req_type    req_ff;
   logic [7:0] pointer_ff, pointer_in;
   logic       expect_ff, expect_in;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_strobe_ff;

   logic         accept;
   logic [7:0]   rd_addr;
   logic         wr_en;
   logic [7:0]   wr_addr;
   logic [7:0]   wr_data;
   logic [7:0]   mem_byte;
   logic         ptr_in_range;
   logic         addr_in_range;
   stat_ctl_type stat_ctl;
   logic [31:0]  stat_value;

   assign busy   = (state_ff == ST_EXEC);
   assign accept = start && !busy;

   // A local read addresses the store directly; every other command reads at the pointer.
   assign rd_addr = (req_word.command == CMD_LOCAL_READ) ? req_word.local_addr : pointer_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff  <= mem[rd_addr[AW-1:0]];
         rd_valid_ff <= valid_ff[rd_addr[AW-1:0]];
         req_ff      <= req_word;
      end
      if (wr_en) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr[AW-1:0]] <= 1'b1;
      end
   end

   // An entry never written since reset reads as zero.
   assign mem_byte      = rd_valid_ff ? rd_data_ff : ZERO_BYTE;
   assign ptr_in_range  = ({1'b0, pointer_ff} < STORE_LIMIT);
   assign addr_in_range = ({1'b0, req_ff.local_addr} < STORE_LIMIT);

   // Execute step: the work of a word is done in the cycle after it is taken; its response is registered.
   always_comb begin
      state_in   = state_ff;
      pointer_in = pointer_ff;
      expect_in  = expect_ff;
      wr_en      = 1'b0;
      wr_addr    = pointer_ff;
      wr_data    = req_ff.data_byte;
      rsp_in     = '0;
      stat_ctl   = '0;
      stat_ctl.err_flags = req_ff.error_flags;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (req_ff.command)
               CMD_ADDR_WRITE: begin
                  expect_in = 1'b1;
                  stat_ctl.bump[CNT_ADDR_WRITE] = 1'b1;
               end
               CMD_ADDR_READ, CMD_TX_DONE: begin
                  if (req_ff.command == CMD_ADDR_READ) begin
                     expect_in = 1'b1;
                     stat_ctl.bump[CNT_ADDR_READ] = 1'b1;
                  end else begin
                     stat_ctl.bump[CNT_TX] = 1'b1;
                  end
                  rsp_in.tx_valid = 1'b1;
                  if (ptr_in_range) begin
                     rsp_in.tx_byte = mem_byte;
                     pointer_in     = pointer_ff + 8'd1;
                  end
               end
               CMD_RX_BYTE: begin
                  stat_ctl.bump[CNT_RX] = 1'b1;
                  if (expect_ff) begin
                     pointer_in = req_ff.data_byte;
                     expect_in  = 1'b0;
                  end else if (ptr_in_range) begin
                     wr_en      = 1'b1;
                     pointer_in = pointer_ff + 8'd1;
                  end
               end
               CMD_STOP: begin
                  stat_ctl.bump[CNT_STOP] = 1'b1;
               end
               CMD_BUS_ERROR: begin
                  stat_ctl.err_write              = 1'b1;
                  stat_ctl.bump[CNT_ACK_FAIL]     = req_ff.error_flags[ERR_ACK_FAIL];
                  stat_ctl.bump[CNT_BUS_ERR]      = req_ff.error_flags[ERR_BUS];
                  stat_ctl.bump[CNT_ARB_LOST]     = req_ff.error_flags[ERR_ARB_LOST];
                  stat_ctl.bump[CNT_OVERRUN]      = req_ff.error_flags[ERR_OVERRUN];
                  stat_ctl.bump[CNT_OTHER]        = req_ff.error_flags[ERR_MISC];
                  // Bus, arbitration and overrun errors all call for a restart.
                  stat_ctl.bump[CNT_RECOVER]      = req_ff.error_flags[ERR_BUS]
                                                    || req_ff.error_flags[ERR_ARB_LOST]
                                                    || req_ff.error_flags[ERR_OVERRUN];
                  rsp_in.reinit_request           = stat_ctl.bump[CNT_RECOVER];
                  expect_in                       = 1'b1;
               end
               CMD_LOCAL_READ: begin
                  if (addr_in_range) begin
                     rsp_in.read_data = mem_byte;
                  end
               end
               CMD_LOCAL_WRITE: begin
                  wr_addr = req_ff.local_addr;
                  wr_en   = addr_in_range;
               end
               CMD_STAT_READ: begin
                  rsp_in.stat_value = stat_value;
               end
               CMD_STAT_CLEAR: begin
                  stat_ctl.clear = 1'b1;
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pointer_ff    <= '0;
         expect_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pointer_ff    <= pointer_in;
         expect_ff     <= expect_in;
         rsp_strobe_ff <= busy;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   i2ct_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .ctl        (stat_ctl),
      .stat_index (req_ff.stat_index),
      .stat_value (stat_value)
   );

`ifndef SYNTHESIS
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not enter execute");
   a_one_exec: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy && rsp_strobe)
      else $error("execute step did not end in a response");
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without an executed word");
   a_no_write_out_of_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({1'b0, wr_addr} < STORE_LIMIT) && busy)
      else $error("store write outside the store");
`endif

endmodule
